### design/tffd_pkg.sv
// ----------------------------------------------------------------------------
// tffd_pkg: shared types and constants for the fall detector
// Word layouts, widths of the root and window datapaths, register map codes.
// ----------------------------------------------------------------------------
package tffd_pkg;

  // Window of recent magnitudes.
  localparam int WINDOW_LEN = 5;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W      = $clog2(WINDOW_LEN + 1);

  // Field widths.
  localparam int ACC_W  = 16;
  localparam int TILT_W = 16;
  localparam int MAG_W  = 17;
  localparam int LIM_W  = 16;
  localparam int COS_W  = 15;
  localparam int PRIO_W = 8;

  // Sum of squares and the digit-serial square root.
  localparam int SQ_W       = 32;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int REM_W      = ROOT_W + 3;

  // Window sum and threshold products.
  localparam int SUM_W  = MAG_W + ((WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1);
  localparam int PROD_W = LIM_W + CNT_W;

  // Configuration port.
  localparam int NUM_REGS  = 5;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_TILT_COS  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FREEFALL  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_REC_LOW   = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_REC_HIGH  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_FALL_PRIO = REG_IDX_W'(4);

  localparam logic [COS_W-1:0]  TILT_COS_RST  = COS_W'(8192);
  localparam logic [LIM_W-1:0]  FREEFALL_RST  = LIM_W'(1280);
  localparam logic [LIM_W-1:0]  REC_LOW_RST   = LIM_W'(2048);
  localparam logic [LIM_W-1:0]  REC_HIGH_RST  = LIM_W'(3072);
  localparam logic [PRIO_W-1:0] FALL_PRIO_RST = PRIO_W'(100);

  // Operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ABORT  = 1'b1;

  // Input word.
  typedef struct packed {
    logic                     opcode;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;
    logic signed [TILT_W-1:0] tilt_z;
  } tffd_in_t;

  // Output word.
  typedef struct packed {
    logic              is_falling;
    logic              priority_update;
    logic [PRIO_W-1:0] priority_value;
  } tffd_out_t;

  // Request to the square root unit.
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } tffd_root_req_t;

  // Status of the square root unit.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } tffd_root_stat_t;

  // Status of the magnitude window.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } tffd_win_stat_t;

endpackage

### design/tffd_isqrt.sv
// ----------------------------------------------------------------------------
// tffd_isqrt: digit-serial integer square root
// Consumes two radicand bits per cycle from a shift register and produces one
// root bit per cycle, rounding down.
// ----------------------------------------------------------------------------
module tffd_isqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  tffd_pkg::tffd_root_req_t req,
  output tffd_pkg::tffd_root_stat_t stat
);
  import tffd_pkg::*;

  logic [SQ_W-1:0]       rad;
  logic [REM_W-1:0]      rem;
  logic [ROOT_W-1:0]     root;
  logic [ROOT_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // One restoring step: bring down two bits, try the next root bit.
  assign rem_sh = {rem[REM_W-3:0], rad[SQ_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});
  assign fits   = (rem_sh >= trial);

  // Control: start loads, ROOT_W steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == ROOT_CNT_W'(ROOT_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ROOT_CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SQ_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.root = root;

  // A new request is only issued when the unit is free.
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("square root started while busy");

  // The done pulse marks exactly the end of a run.
  a_done_at_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("square root finished without a done pulse");

endmodule

### design/tffd_window.sv
// ----------------------------------------------------------------------------
// tffd_window: window of recent magnitudes with a running sum
// Each push replaces the oldest entry and adjusts the sum by the difference.
// ----------------------------------------------------------------------------
module tffd_window (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [tffd_pkg::MAG_W-1:0] mag,
  output tffd_pkg::tffd_win_stat_t   stat
);
  import tffd_pkg::*;

  logic [MAG_W-1:0]  entry [WINDOW_LEN];
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;

  // The sum stays exact: it drops the evicted entry and adds the new one.
  assign sum_next = sum - SUM_W'(entry[slot]) + SUM_W'(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        entry[i] <= '0;
      end
      slot  <= '0;
      count <= '0;
      sum   <= '0;
    end else if (push) begin
      entry[slot] <= mag;
      sum         <= sum_next;
      if (slot == SLOT_W'(WINDOW_LEN - 1)) begin
        slot <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
      if (count != CNT_W'(WINDOW_LEN)) begin
        count <= count + 1'b1;
      end
    end
  end

  assign stat.sum   = sum;
  assign stat.count = count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW_LEN))
    else $error("window fill count past window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot < SLOT_W'(WINDOW_LEN) || WINDOW_LEN == 1)
    else $error("window slot out of range");

endmodule

### design/tilt_freefall_fall_detector_top.sv
// ----------------------------------------------------------------------------
// tilt_freefall_fall_detector_top: freefall fall detector with recovery band
// Squares the axes on one multiplier, takes a digit-serial root, keeps a
// window sum and decides the falling flag against the configured limits.
// ----------------------------------------------------------------------------
// Sample word: the three squares are summed in S_SQ, the 16-step root runs in
// S_ROOT and the result is registered from S_DECIDE; the next word is taken
// once the block is back in S_IDLE. Abort word: goes straight to S_DECIDE.
// A finished result waits in the output register while the next word is
// taken. Reset clears the window, fill count, flag and output valid at once.
module tilt_freefall_fall_detector_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tffd_pkg::tffd_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tffd_pkg::tffd_out_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tffd_pkg::PADDR_W-1:0]  paddr,
  input  logic [tffd_pkg::DATA_W-1:0]   pwdata,
  output logic [tffd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tffd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SQ     = 4'b0010,
    S_ROOT   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [COS_W-1:0]     tilt_cos_limit;
  logic [LIM_W-1:0]     freefall_limit;
  logic [LIM_W-1:0]     recovery_low;
  logic [LIM_W-1:0]     recovery_high;
  logic [PRIO_W-1:0]    fall_priority;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  // Word held during processing.
  logic              abort;
  logic              tilt_ok;
  logic [ACC_W-1:0]  axis [3];
  logic [1:0]        sq_cnt;
  logic [SQ_W-1:0]   acc;
  logic [SQ_W-1:0]   acc_next;
  logic              falling;

  logic              accept;
  logic              out_free;
  logic [ACC_W-1:0]  abs_x;
  logic [ACC_W-1:0]  abs_y;
  logic [ACC_W-1:0]  abs_z;
  logic [TILT_W-1:0] abs_t;

  tffd_root_req_t  root_req;
  tffd_root_stat_t root_stat;
  tffd_win_stat_t  win_stat;
  logic            push;

  logic [PROD_W-1:0] ff_prod;
  logic [PROD_W-1:0] low_prod;
  logic [PROD_W-1:0] high_prod;
  logic              falling_next;
  logic              changed;
  logic [PRIO_W-1:0] prio;

  // APB register file; writes complete in the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_cos_limit <= TILT_COS_RST;
      freefall_limit <= FREEFALL_RST;
      recovery_low   <= REC_LOW_RST;
      recovery_high  <= REC_HIGH_RST;
      fall_priority  <= FALL_PRIO_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TILT_COS:  tilt_cos_limit <= pwdata[COS_W-1:0];
        REG_FREEFALL:  freefall_limit <= pwdata[LIM_W-1:0];
        REG_REC_LOW:   recovery_low   <= pwdata[LIM_W-1:0];
        REG_REC_HIGH:  recovery_high  <= pwdata[LIM_W-1:0];
        REG_FALL_PRIO: fall_priority  <= pwdata[PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TILT_COS:  prdata = DATA_W'(tilt_cos_limit);
      REG_FREEFALL:  prdata = DATA_W'(freefall_limit);
      REG_REC_LOW:   prdata = DATA_W'(recovery_low);
      REG_REC_HIGH:  prdata = DATA_W'(recovery_high);
      REG_FALL_PRIO: prdata = DATA_W'(fall_priority);
      default:       prdata = '0;
    endcase
  end

  // Magnitudes of the input fields; the most negative code maps to 2^15.
  assign abs_x = in_data.accel_x[ACC_W-1] ? (~in_data.accel_x + 1'b1) : in_data.accel_x;
  assign abs_y = in_data.accel_y[ACC_W-1] ? (~in_data.accel_y + 1'b1) : in_data.accel_y;
  assign abs_z = in_data.accel_z[ACC_W-1] ? (~in_data.accel_z + 1'b1) : in_data.accel_z;
  assign abs_t = in_data.tilt_z[TILT_W-1] ? (~in_data.tilt_z + 1'b1) : in_data.tilt_z;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_data.opcode == OP_ABORT) ? S_DECIDE : S_SQ;
        end
      end
      S_SQ: begin
        if (sq_cnt == 2'd2) begin
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_stat.done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the word; the three axes then rotate past one multiplier.
  assign acc_next = acc + (SQ_W'(axis[0]) * SQ_W'(axis[0]));

  always_ff @(posedge clk) begin
    if (accept) begin
      abort   <= (in_data.opcode == OP_ABORT);
      tilt_ok <= (abs_t < TILT_W'(tilt_cos_limit));
      axis[0] <= abs_x;
      axis[1] <= abs_y;
      axis[2] <= abs_z;
      acc     <= '0;
      sq_cnt  <= '0;
    end else if (state == S_SQ) begin
      axis[0] <= axis[1];
      axis[1] <= axis[2];
      acc     <= acc_next;
      sq_cnt  <= sq_cnt + 1'b1;
    end
  end

  // Root request goes out with the final partial sum.
  assign root_req.start    = (state == S_SQ) && (sq_cnt == 2'd2);
  assign root_req.radicand = acc_next;

  tffd_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (root_req),
    .stat (root_stat)
  );

  assign push = (state == S_ROOT) && root_stat.done;

  tffd_window u_window (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .mag  (MAG_W'(root_stat.root)),
    .stat (win_stat)
  );

  // Averages compared as window sum against limit times fill count.
  assign ff_prod   = PROD_W'(freefall_limit) * PROD_W'(win_stat.count);
  assign low_prod  = PROD_W'(recovery_low) * PROD_W'(win_stat.count);
  assign high_prod = PROD_W'(recovery_high) * PROD_W'(win_stat.count);

  always_comb begin
    falling_next = falling;
    changed      = 1'b0;
    prio         = '0;
    if (abort) begin
      falling_next = 1'b0;
      changed      = falling;
    end else if (!falling) begin
      if (tilt_ok && (win_stat.sum < SUM_W'(ff_prod))) begin
        falling_next = 1'b1;
        changed      = 1'b1;
        prio         = fall_priority;
      end
    end else if ((win_stat.sum > SUM_W'(low_prod)) &&
                 (win_stat.sum < SUM_W'(high_prod))) begin
      falling_next = 1'b0;
      changed      = 1'b1;
    end
  end

  // Falling flag and output register; a new result replaces one being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      falling   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DECIDE) && out_free) begin
        falling   <= falling_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DECIDE) && out_free) begin
      out_data.is_falling      <= falling_next;
      out_data.priority_update <= changed;
      out_data.priority_value  <= prio;
    end
  end

  // A result only appears from the decision step.
  a_out_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DECIDE))
    else $error("result word raised outside the decision step");

  // A word without a flag change carries no priority.
  a_quiet_prio: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.priority_update) |-> (out_data.priority_value == '0))
    else $error("priority value set without an update");

endmodule
